>>> design/modulated_audio_delay_line_core_assert.svh
// Assertion macros shared by the delay line checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef MODULATED_AUDIO_DELAY_LINE_CORE_ASSERT_SVH
`define MODULATED_AUDIO_DELAY_LINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MDL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MDL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mdl_pkg.sv
// Shared types and constants for the modulated audio delay line.
// No dependencies; imported by every module of the block except mdl_ram.
package mdl_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 524288;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int KNOB_IN_W = 16;
  localparam int KNOB_W    = 24;
  localparam int RATE_W    = 18;
  localparam int NOTE_W    = 14;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH = CFG_IDX_W'(1);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [NOTE_W-1:0] NOTE_RESET = NOTE_W'(500);

  // Smoother and delay scaling
  localparam int KNOB_ALPHA    = 1678;
  localparam int MS_PER_SECOND = 1000;
  localparam int KNOB_SPAN     = 8;
  localparam int DIV_C         = MS_PER_SECOND / KNOB_SPAN;

  // Shared multiplier and reciprocal divide by DIV_C
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int SCALE_SHIFT = 24;
  localparam int RECIP_SHIFT = 38;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam logic [MUL_W-1:0] RECIP_M = MUL_W'((64'd1 << RECIP_SHIFT) / DIV_C);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SM_MUL,
    ST_SM_UPD,
    ST_SC_MUL,
    ST_RC_MUL,
    ST_CORR,
    ST_FIX,
    ST_RD,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SMOOTH,
    MUL_SPAN,
    MUL_SCALE,
    MUL_RECIP,
    MUL_CORR
  } mul_op_t;

  typedef struct packed {
    logic    clr_en;
    logic    load;
    mul_op_t mul_op;
    logic    knob_upd;
    logic    delay_upd;
    logic    rd_issue;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

>>> design/mdl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/mdl_ctrl.sv
// Controller of the delay line: sequences clear pass, smoothing, delay maths
// and store read. Depends on mdl_pkg.
module mdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  mdl_pkg::dp_stat_t stat,
  output logic              in_ready,
  output logic              out_valid,
  output mdl_pkg::dp_cmd_t  cmd
);
  import mdl_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_SM_MUL;
      ST_SM_MUL: state_next = ST_SM_UPD;
      ST_SM_UPD: state_next = ST_SC_MUL;
      ST_SC_MUL: state_next = ST_RC_MUL;
      ST_RC_MUL: state_next = ST_CORR;
      ST_CORR:   state_next = ST_FIX;
      ST_FIX:    state_next = ST_RD;
      ST_RD:     state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SM_MUL: cmd.mul_op = MUL_SMOOTH;
      ST_SM_UPD: begin
        cmd.knob_upd = 1'b1;
        cmd.mul_op   = MUL_SPAN;
      end
      ST_SC_MUL: cmd.mul_op = MUL_SCALE;
      ST_RC_MUL: cmd.mul_op = MUL_RECIP;
      ST_CORR:   cmd.mul_op = MUL_CORR;
      ST_FIX:    cmd.delay_upd = 1'b1;
      ST_RD:     cmd.rd_issue = 1'b1;
      ST_OUT:    cmd.out_load = out_free;
      default:   cmd = '0;
    endcase
  end

  // Result beat flag: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> design/mdl_dp.sv
// Datapath of the delay line: config registers, sample store, smoother,
// shared multiplier and delay arithmetic. Depends on mdl_pkg and mdl_ram.
module mdl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mdl_pkg::dp_cmd_t                    cmd,
  output mdl_pkg::dp_stat_t                   stat,
  input  logic                                cfg_valid,
  input  logic [mdl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mdl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [mdl_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [mdl_pkg::KNOB_IN_W-1:0]       knob_target,
  output logic signed [mdl_pkg::SAMPLE_W-1:0] delayed_sample
);
  import mdl_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W+1)'(STORE_DEPTH);
  localparam logic [Q_W-1:0]    SAT_MAX   = Q_W'(STORE_DEPTH - 1);
  localparam int                SM_SUM_W  = 36;
  localparam logic [SM_SUM_W-1:0] SM_ROUND = SM_SUM_W'(1) << (SCALE_SHIFT - 1);

  logic [RATE_W-1:0]   sample_rate_hz;
  logic [NOTE_W-1:0]   note_length_ms;
  logic [ADDR_W-1:0]   wp;
  logic [ADDR_W-1:0]   clr_addr;
  logic [KNOB_W-1:0]   knob;
  logic [KNOB_W-1:0]   knob_next;
  logic [KNOB_W-1:0]   target;
  logic [KNOB_W-1:0]   mag;
  logic                dir_down;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [PROD_W-1:0]   prod;
  logic [SM_SUM_W-1:0] sm_sum;
  logic [KNOB_W-1:0]   sm_step;
  logic [MUL_W-1:0]    x;
  logic [Q_W-1:0]      q0;
  logic [MUL_W:0]      rem;
  logic [Q_W-1:0]      q;
  logic [ADDR_W-1:0]   delay;
  logic [ADDR_W-1:0]   delay_next;
  logic [ADDR_W:0]     rd_full;
  logic [ADDR_W-1:0]   rd_addr;
  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic [SAMPLE_W-1:0] ram_wr_data;
  logic [SAMPLE_W-1:0] ram_rd_data;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz <= RATE_RESET;
      note_length_ms <= NOTE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SAMPLE_RATE: sample_rate_hz <= cfg_data[RATE_W-1:0];
        CFG_NOTE_LENGTH: note_length_ms <= cfg_data[NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en && clr_addr != LAST_ADDR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign stat.clear_last = (clr_addr == LAST_ADDR);

  // Store: clear pass or the incoming sample on the write port
  assign ram_wr_en   = cmd.clr_en || cmd.load;
  assign ram_wr_addr = cmd.clr_en ? clr_addr : wp;
  assign ram_wr_data = cmd.clr_en ? '0 : sample_in;

  // Read index: write position minus delay, with wrap
  always_comb begin
    if (wp >= delay) begin
      rd_full = {1'b0, wp} - {1'b0, delay};
    end else begin
      rd_full = {1'b0, wp} + DEPTH_EXT - {1'b0, delay};
    end
    rd_addr = rd_full[ADDR_W-1:0];
  end

  mdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Advance the write position after the read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cmd.rd_issue) begin
      wp <= (wp == LAST_ADDR) ? '0 : wp + ADDR_W'(1);
    end
  end

  // Capture distance and direction to the knob target
  assign target = {knob_target, {(KNOB_W-KNOB_IN_W){1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir_down <= (target < knob);
      mag      <= (target < knob) ? knob - target : target - knob;
    end
  end

  // Smoother step, rounded half away from zero
  assign sm_sum  = prod[SM_SUM_W-1:0] + SM_ROUND;
  assign sm_step = KNOB_W'(sm_sum[SM_SUM_W-1:SCALE_SHIFT]);
  assign knob_next = dir_down ? knob - sm_step : knob + sm_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      knob <= '0;
    end else if (cmd.knob_upd) begin
      knob <= knob_next;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_SMOOTH: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(KNOB_ALPHA);
      end
      MUL_SPAN: begin
        mul_a = MUL_W'(note_length_ms);
        mul_b = MUL_W'(sample_rate_hz);
      end
      MUL_SCALE: begin
        mul_a = MUL_W'(knob);
        mul_b = prod[MUL_W-1:0];
      end
      MUL_RECIP: begin
        mul_a = prod[SCALE_SHIFT +: MUL_W];
        mul_b = RECIP_M;
      end
      MUL_CORR: begin
        mul_a = MUL_W'(prod[RECIP_SHIFT +: Q_W]);
        mul_b = MUL_W'(DIV_C);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register each product; hold it when the multiplier is unused
  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // Keep the dividend and the first quotient estimate
  always_ff @(posedge clk) begin
    if (cmd.mul_op == MUL_RECIP) begin
      x <= prod[SCALE_SHIFT +: MUL_W];
    end
    if (cmd.mul_op == MUL_CORR) begin
      q0 <= prod[RECIP_SHIFT +: Q_W];
    end
  end

  // Correct the estimate by one, then saturate to the store
  assign rem = {1'b0, x} - prod[MUL_W:0];
  assign q   = (rem >= (MUL_W+1)'(DIV_C)) ? q0 + Q_W'(1) : q0;
  assign delay_next = (q > SAT_MAX) ? LAST_ADDR : q[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.delay_upd) begin
      delay <= delay_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      delayed_sample <= ram_rd_data;
    end
  end

endmodule

>>> design/modulated_audio_delay_line_core.sv
// Top level of the modulated audio delay line: controller plus datapath.
// Depends on mdl_pkg, mdl_ctrl, mdl_dp (and mdl_ram below it).
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | in_valid / in_ready  | sample_in, knob_target
//   result   | out_valid / out_ready| delayed_sample
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A result beat is offered once its item has gone through five products in turn on
// the single shared 32x32 multiplier, then the correction, the store read and the
// load; the next item is taken once the load is done.
// After reset a clearing pass writes zero to all STORE_DEPTH (524288)
// entries, one per cycle; no item is taken during it, config always is.
// A new item is taken while a result waits; it then holds in its output stage.
module modulated_audio_delay_line_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mdl_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [mdl_pkg::KNOB_IN_W-1:0]       knob_target,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mdl_pkg::SAMPLE_W-1:0] delayed_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mdl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mdl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mdl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Register writes are never held off
  assign cfg_ready = 1'b1;

  mdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mdl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_in      (sample_in),
    .knob_target    (knob_target),
    .delayed_sample (delayed_sample)
  );

endmodule

>>> design/mdl_chk.sv
// Port-level checker for the delay line core, bound to the top level.
// Depends on mdl_pkg and modulated_audio_delay_line_core_assert.svh.
`include "modulated_audio_delay_line_core_assert.svh"

module mdl_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mdl_pkg::SAMPLE_W-1:0] delayed_sample
);
  import mdl_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic       out_stall;
  logic [1:0] pending;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= 2'(pending + {1'b0, in_acc} - {1'b0, out_acc});
    end
  end

  // A stalled result beat holds its value
  `MDL_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(delayed_sample), "beat not held")

  // One item in the arithmetic at a time
  `MDL_ASSERT_NXT(a_single_item, in_acc, !in_ready, "input still ready after accepting a beat")

  // No result beat without an item behind it
  `MDL_ASSERT_IMP(a_no_orphan, out_valid, pending != 2'd0, "result beat with no item pending")

  // At most one waiting result plus one item in flight
  `MDL_ASSERT_IMP(a_pending_bound, in_acc, pending < 2'd2, "too many items in flight")

endmodule

bind modulated_audio_delay_line_core mdl_chk u_chk (.*);

>>> sim/modulated_audio_delay_line_core_test.sv
// Self-checking testbench for modulated_audio_delay_line_core: it predicts each delayed sample
// from its own model of the store, the knob smoother and the delay scaling.
// Depends on mdl_pkg and the core; no files or arguments are read.
module modulated_audio_delay_line_core_test;
  import mdl_pkg::*;

  // Spare register indexes that the core must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // Smoother and delay constants of the predictor
  localparam longint unsigned SMOOTH_ALPHA = 1678;
  localparam longint unsigned SMOOTH_HALF  = 64'd1 << 23;
  localparam longint unsigned DELAY_SPAN   = 8;
  localparam longint unsigned DELAY_DIV    = 64'd1000 << 24;
  localparam int unsigned     MAX_DELAY    = STORE_DEPTH - 1;

  localparam int IDLE_PCT     = 34;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [KNOB_IN_W-1:0] knob_target;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] delayed_sample;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state
  bit [SAMPLE_W-1:0] echo_store [STORE_DEPTH];
  int unsigned write_pos = 0;
  logic [KNOB_W-1:0] knob_smooth = '0;
  logic [RATE_W-1:0] rate_reg = RATE_RESET;
  logic [NOTE_W-1:0] note_reg = NOTE_RESET;

  logic [SAMPLE_W-1:0] expected_echoes [$];

  // Run control and tallies
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_requests = 0;
  int hold_done = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int register_writes = 0;
  int full_delay_reads = 0;
  int zero_delay_reads = 0;

  modulated_audio_delay_line_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_in      (sample_in),
    .knob_target    (knob_target),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .delayed_sample (delayed_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  // Write the sample, advance the smoother, then read back at the scaled delay
  function automatic logic [SAMPLE_W-1:0] next_echo(input logic [SAMPLE_W-1:0] sample,
                                                    input logic [KNOB_IN_W-1:0] knob);
    logic [KNOB_W-1:0] target;
    longint unsigned mag;
    longint unsigned stepval;
    longint unsigned scaled;
    longint unsigned delay;
    int unsigned rd_pos;
    logic [SAMPLE_W-1:0] echo;
    echo_store[write_pos] = sample;
    target = {knob, 8'h00};
    if (target >= knob_smooth) begin
      mag = longint'(target - knob_smooth) * SMOOTH_ALPHA;
      stepval = (mag + SMOOTH_HALF) >> 24;
      knob_smooth = knob_smooth + KNOB_W'(stepval);
    end else begin
      mag = longint'(knob_smooth - target) * SMOOTH_ALPHA;
      stepval = (mag + SMOOTH_HALF) >> 24;
      knob_smooth = knob_smooth - KNOB_W'(stepval);
    end
    scaled = knob_smooth;
    scaled = scaled * DELAY_SPAN;
    scaled = scaled * note_reg;
    scaled = scaled * rate_reg;
    delay = scaled / DELAY_DIV;
    if (delay > MAX_DELAY) delay = MAX_DELAY;
    if (delay == MAX_DELAY) full_delay_reads++;
    if (delay == 0) zero_delay_reads++;
    if (write_pos >= delay) rd_pos = write_pos - int'(delay);
    else rd_pos = write_pos + STORE_DEPTH - int'(delay);
    echo = echo_store[rd_pos];
    write_pos = (write_pos + 1 == STORE_DEPTH) ? 0 : write_pos + 1;
    return echo;
  endfunction

  // Offer one sample beat; predict its echo when it is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic [KNOB_IN_W-1:0] knob);
    if (sender_idles) begin
      while ($urandom_range(99) < IDLE_PCT) @(negedge clk);
    end
    in_valid = 1'b1;
    sample_in = sample;
    knob_target = knob;
    do @(posedge clk); while (!in_ready);
    expected_echoes.push_back(next_echo(sample, knob));
    samples_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAMPLE_RATE: rate_reg = value;
      CFG_NOTE_LENGTH: note_reg = value[NOTE_W-1:0];
      default: ;
    endcase
    register_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every echo has come back and the core has gone quiet
  task automatic settle;
    while (expected_echoes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Extremes of both fields under the reset settings
  task automatic test_field_extremes;
    send_sample(24'h7FFFFF, 16'hFFFF);
    send_sample(24'h800000, 16'hFFFF);
    send_sample(24'h000000, 16'h0000);
    send_sample(24'hFFFFFF, 16'h0000);
    send_sample(24'h000001, 16'h8000);
    send_sample(24'h555555, 16'h5555);
    send_sample(24'hAAAAAA, 16'hAAAA);
    send_sample(24'h800000, 16'h0001);
    send_sample(24'h123456, 16'hFFFF);
    settle();
  endtask

  // Zero rate, then zero note length: each echo is the current sample
  task automatic test_zero_delay;
    write_register(CFG_SAMPLE_RATE, RATE_W'(0));
    send_sample(24'h7FFFFF, 16'hFFFF);
    send_sample(24'h800000, 16'hFFFF);
    send_sample(24'h3C3C3C, 16'hFFFF);
    settle();
    write_register(CFG_SAMPLE_RATE, RATE_W'(192000));
    write_register(CFG_NOTE_LENGTH, CFG_DATA_W'(0));
    send_sample(24'hFFFFFF, 16'h0000);
    send_sample(24'h000001, 16'hFFFF);
    send_sample(24'hC3C3C3, 16'h7FFF);
    settle();
  endtask

  // Writes to the spare indexes must leave both settings alone
  task automatic test_spare_index;
    write_register(CFG_SAMPLE_RATE, RATE_W'(8000));
    write_register(CFG_NOTE_LENGTH, CFG_DATA_W'(10000));
    write_register(CFG_SPARE_A, '1);
    write_register(CFG_SPARE_B, CFG_DATA_W'(0));
    send_sample(24'h0F0F0F, 16'hFFFF);
    send_sample(24'hF0F0F0, 16'hFFFF);
    send_sample(24'h7FFFFF, 16'h0000);
    settle();
  endtask

  // Oversized settings with the knob held high push the delay into saturation
  task automatic test_delay_saturation;
    write_register(CFG_SAMPLE_RATE, '1);
    write_register(CFG_NOTE_LENGTH, '1);
    repeat (250) send_sample(SAMPLE_W'($urandom), 16'hFFFF);
    settle();
  endtask

  // Random settings and samples; the knob holds a per-phase target for half the samples
  task automatic test_random_phases(input int phases, input int per_phase);
    logic [KNOB_IN_W-1:0] held;
    logic [KNOB_IN_W-1:0] knob;
    for (int p = 0; p < phases; p++) begin
      write_register(CFG_SAMPLE_RATE, RATE_W'($urandom_range(192000, 8000)));
      if ($urandom_range(3) == 0)
        write_register(CFG_NOTE_LENGTH, CFG_DATA_W'($urandom_range(10000)));
      else
        write_register(CFG_NOTE_LENGTH, CFG_DATA_W'($urandom_range(2)));
      held = KNOB_IN_W'($urandom);
      if (p % 3 == 2) held = 16'h0000;
      for (int i = 0; i < per_phase; i++) begin
        case ($urandom_range(3))
          0: knob = KNOB_IN_W'($urandom);
          3: knob = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: knob = held;
        endcase
        send_sample(SAMPLE_W'($urandom), knob);
      end
      settle();
    end
  endtask

  // Hold the result side off while samples keep coming, so the core backs up
  task automatic test_back_pressure;
    write_register(CFG_SAMPLE_RATE, RATE_W'(8000));
    write_register(CFG_NOTE_LENGTH, CFG_DATA_W'(1));
    hold_requests++;
    repeat (60) send_sample(SAMPLE_W'($urandom), KNOB_IN_W'($urandom));
    settle();
  endtask

  // Back-to-back beats with no idling on either side
  task automatic test_steady_stream;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    repeat (200) send_sample(SAMPLE_W'($urandom), KNOB_IN_W'($urandom));
    settle();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_requests) begin
        hold_done++;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = !receiver_idles || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each result beat with the oldest expected echo
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_echoes.size() == 0) begin
        $error("delayed_sample: beat with no expected echo, got %0d", delayed_sample);
        mismatches++;
      end else begin
        logic [SAMPLE_W-1:0] want;
        want = expected_echoes.pop_front();
        results_checked++;
        if (delayed_sample !== want) begin
          $error("delayed_sample mismatch: expected %0d, got %0d",
                 $signed(want), delayed_sample);
          mismatches++;
        end
      end
    end
  end

  // Watchdog, sized for the clearing pass plus a slow run several times over
  initial begin
    #24000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    knob_target = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SAMPLE_RATE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_zero_delay();
    test_spare_index();
    test_delay_saturation();
    test_random_phases(6, 240);
    test_back_pressure();
    test_steady_stream();

    if (expected_echoes.size() != 0) begin
      $error("delayed_sample: %0d expected echoes never arrived", expected_echoes.size());
      mismatches++;
    end
    $display("Sent %0d samples across %0d register writes; checked %0d echoes.",
             samples_sent, register_writes, results_checked);
    $display("Reads at zero delay: %0d, at full store delay: %0d, mismatches: %0d.",
             zero_delay_reads, full_delay_reads, mismatches);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
